// ===== rtl/core/dm1frf_pkg.sv =====
// Package for the DM1 fault report filter.
// Holds the item structs, table entry type and decode constants.
// No dependencies.
`timescale 1ns / 1ps

package dm1frf_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam logic [31:0] HOLD_RESET = 32'd3600;

  localparam logic        CMD_TICK = 1'b0;
  localparam logic        CMD_DTC  = 1'b1;

  localparam logic [18:0] SPN_NONE  = 19'h00000;
  localparam logic [18:0] SPN_LIMIT = 19'h7FFFF;

  localparam logic [7:0]  LAMP_ANY_MASK = 8'hFC;
  localparam logic [7:0]  MIL_MASK      = 8'hC0;
  localparam logic [7:0]  STOP_MASK     = 8'h30;
  localparam logic [7:0]  WARN_MASK     = 8'h0C;

  typedef struct packed {
    logic        command;
    logic [7:0]  lamp_byte;
    logic [31:0] dtc_word;
  } dtc_item_t;

  typedef struct packed {
    logic [18:0] spn;
    logic [4:0]  fmi;
    logic [6:0]  occurrence;
    logic        mil_on;
    logic        stop_on;
    logic        warn_on;
    logic        table_full;
  } report_item_t;

  typedef struct packed {
    logic [18:0] spn;
    logic [6:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/dm1_fault_report_filter.sv =====
// DM1 fault report filter: decodes trouble code items, tracks reported SPNs
// in a RAM table searched one entry per cycle, and emits filtered reports.
// Depends on dm1frf_pkg and dm1frf_ram.
// A trouble code item is scanned with one read per table entry; its read data
// passes the RAM read register, then the decision step registers a report
// unless the item is suppressed; the next item is accepted back in idle.
// Tick, lamp-clear and invalid-SPN items need no table scan. One item is in work
// at a time; a waiting report does not block acceptance of the next item, but
// it holds a later trouble code item in its decision step until it is taken.
// Reset clears all valid bits and the seconds counter and loads hold_seconds
// with 3600; the table RAM contents are not cleared.
`timescale 1ns / 1ps

module dm1_fault_report_filter #(
  parameter int TABLE_DEPTH = dm1frf_pkg::TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     dtc_valid,
  output logic                     dtc_ready,
  input  dm1frf_pkg::dtc_item_t    dtc,
  output logic                     report_valid,
  input  logic                     report_ready,
  output dm1frf_pkg::report_item_t report,
  input  logic                     cfg_we,
  input  logic [31:0]              cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]             state;
  logic [31:0]            hold_seconds;
  logic [31:0]            seconds;
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic [18:0]            cur_spn;
  logic [4:0]             cur_fmi;
  logic [6:0]             cur_oc;
  logic                   cur_mil;
  logic                   cur_stop;
  logic                   cur_warn;

  logic [IDX_W-1:0]       idx;
  logic                   issuing;
  logic                   rd_pending;
  logic [IDX_W-1:0]       rd_idx;

  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [6:0]             hit_count;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  dm1frf_pkg::entry_t     rd_entry;
  logic [dm1frf_pkg::ENTRY_W-1:0] rd_bits;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  dm1frf_pkg::entry_t     mem_wentry;

  logic [18:0]            in_spn;
  logic                   in_accept;
  logic                   out_free;
  logic                   suppress;
  logic                   report_load;
  logic                   entry_match;

  assign dtc_ready = (state == ST_IDLE);
  assign in_accept = dtc_valid && dtc_ready;
  assign in_spn    = {dtc.dtc_word[23:21], dtc.dtc_word[15:0]};
  assign out_free  = !report_valid || report_ready;

  assign rd_entry    = dm1frf_pkg::entry_t'(rd_bits);
  assign entry_match = entry_valid[rd_idx] && (rd_entry.spn == cur_spn);

  assign suppress    = hit && ((hit_count >= cur_oc) || (seconds < hold_seconds));
  assign report_load = (state == ST_DECIDE) && !suppress && out_free;

  // All table reads of an item finish before its single write, so no
  // forwarding is needed between the write port and the read port.
  assign mem_we           = report_load && (hit || free_found);
  assign mem_waddr        = hit ? hit_idx : free_idx;
  assign mem_wentry.spn   = cur_spn;
  assign mem_wentry.count = cur_oc;

  dm1frf_ram #(
    .WIDTH (dm1frf_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wentry),
    .raddr (idx),
    .rdata (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_seconds <= dm1frf_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      hold_seconds <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seconds      <= '0;
      entry_valid  <= '0;
      report_valid <= 1'b0;
      issuing      <= 1'b0;
      rd_pending   <= 1'b0;
      hit          <= 1'b0;
      free_found   <= 1'b0;
    end else begin
      report_valid <= report_load || (report_valid && !report_ready);
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (dtc.command == dm1frf_pkg::CMD_TICK) begin
              if (seconds != '1) begin
                seconds <= seconds + 32'd1;
              end
            end else if ((dtc.lamp_byte & dm1frf_pkg::LAMP_ANY_MASK) == 8'h00) begin
              entry_valid <= '0;
            end else if (in_spn != dm1frf_pkg::SPN_NONE &&
                         in_spn != dm1frf_pkg::SPN_LIMIT) begin
              cur_spn    <= in_spn;
              cur_fmi    <= dtc.dtc_word[20:16];
              cur_oc     <= dtc.dtc_word[30:24];
              cur_mil    <= (dtc.lamp_byte & dm1frf_pkg::MIL_MASK) != 8'h00;
              cur_stop   <= (dtc.lamp_byte & dm1frf_pkg::STOP_MASK) != 8'h00;
              cur_warn   <= (dtc.lamp_byte & dm1frf_pkg::WARN_MASK) != 8'h00;
              idx        <= '0;
              issuing    <= 1'b1;
              rd_pending <= 1'b0;
              hit        <= 1'b0;
              free_found <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pending <= issuing;
          rd_idx     <= idx;
          if (issuing) begin
            if (idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (rd_pending) begin
            if (entry_match && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= rd_idx;
              hit_count <= rd_entry.count;
            end else if (!entry_valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == LAST_IDX) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (suppress) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            seconds <= '0;
            if (!hit && free_found) begin
              entry_valid[free_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      report.spn        <= cur_spn;
      report.fmi        <= cur_fmi;
      report.occurrence <= cur_oc;
      report.mil_on     <= cur_mil;
      report.stop_on    <= cur_stop;
      report.warn_on    <= cur_warn;
      report.table_full <= !hit && !free_found;
    end
  end

  a_report_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(state) == ST_DECIDE)
    else $error("Report raised outside the decision step.");

  a_seconds_restart: assert property (@(posedge clk) disable iff (rst)
    report_load |=> seconds == 32'd0)
    else $error("Seconds counter not restarted after a report.");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && hit) |-> entry_valid[hit_idx])
    else $error("Table hit points at an invalid entry.");

  a_free_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && !hit && free_found) |-> !entry_valid[free_idx])
    else $error("Free entry chosen for a new SPN is already in use.");

endmodule

// ===== rtl/core/dm1frf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
`timescale 1ns / 1ps

module dm1frf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
